// File: rtl/single_wire_sensor_frame_decoder_unit_assert.svh
// assertion macros for the single wire sensor frame decoder
`ifndef SINGLE_WIRE_SENSOR_FRAME_DECODER_UNIT_ASSERT_SVH
`define SINGLE_WIRE_SENSOR_FRAME_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define SWSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swsd assertion failed (same cycle)");

// next-cycle implication, checked while out of reset
`define SWSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swsd assertion failed (next cycle)");

`endif

// File: rtl/swsd_pkg.sv
// shared types and constants of the single wire sensor frame decoder
package swsd_pkg;

  localparam int unsigned FRAME_BYTES = 5;
  localparam int unsigned FRAME_BITS  = 40;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // floor(x / 10) == (x * 52429) >> 19 for any 15-bit x
  localparam logic [15:0] RECIP_TEN   = 16'd52429;
  localparam int unsigned RECIP_SHIFT = 19;

  localparam logic [7:0] THRESH_RESET  = 8'd50;
  localparam logic [7:0] TIMEOUT_RESET = 8'd255;

  typedef enum logic [0:0] {
    REG_ONE_THRESHOLD = 1'b0,
    REG_TIMEOUT_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STATUS_GOOD  = 2'd0,
    STATUS_SHORT = 2'd1,
    STATUS_CSUM  = 2'd2
  } frame_status_t;

  // finished frame handed from the front to the back
  typedef struct packed {
    logic [FRAME_BYTES-1:0][7:0] bytes;
    logic [5:0]                  bits;
  } frame_rec_t;

endpackage

// File: rtl/swsd_queue.sv
// short queue of finished frames between front and back
module swsd_queue
  import swsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_rec_t push_rec,
  input  logic       pop,
  output frame_rec_t head_rec,
  output logic       full,
  output logic       not_empty
);

  frame_rec_t              mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr;
  logic [QUEUE_AW-1:0]     rd_ptr;
  logic [QUEUE_AW:0]       count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head_rec  = mem[rd_ptr];
  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);

endmodule

// File: rtl/swsd_front.sv
// front: per-tick run counting, bit slicing and frame end detection
module swsd_front
  import swsd_pkg::*;
#(
  parameter int unsigned MAX_TRANSITIONS  = 85,
  parameter int unsigned SKIP_TRANSITIONS = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic       start_capture,
  input  logic       pin_level,
  input  logic [7:0] one_threshold,
  input  logic [7:0] timeout_limit,
  output logic       push,
  output frame_rec_t push_rec
);

  localparam logic [6:0] MAX_T  = 7'(MAX_TRANSITIONS);
  localparam logic [6:0] SKIP_T = 7'(SKIP_TRANSITIONS);
  localparam logic [5:0] NBITS  = 6'(FRAME_BITS);

  logic                        capturing, capturing_next;
  logic                        last_level, last_level_next;
  logic [7:0]                  run_length, run_length_next;
  logic [6:0]                  trans_idx, trans_idx_next;
  logic [5:0]                  bit_count, bit_count_next;
  logic [FRAME_BYTES-1:0][7:0] frame_bytes, frame_bytes_next;
  logic                        done;

  always_comb begin
    logic [7:0] limit;
    logic [7:0] run_inc;
    logic [2:0] byte_idx;
    logic       bit_val;

    capturing_next   = capturing;
    last_level_next  = last_level;
    run_length_next  = run_length;
    trans_idx_next   = trans_idx;
    bit_count_next   = bit_count;
    frame_bytes_next = frame_bytes;
    done             = 1'b0;

    // a start clears the frame and its own sample is the first one
    if (start_capture) begin
      capturing_next   = 1'b1;
      last_level_next  = 1'b1;
      run_length_next  = '0;
      trans_idx_next   = '0;
      bit_count_next   = '0;
      frame_bytes_next = '0;
    end

    limit    = (timeout_limit == 8'd0) ? 8'd1 : timeout_limit;
    run_inc  = (run_length_next == 8'hFF) ? run_length_next : run_length_next + 8'd1;
    byte_idx = bit_count_next[5:3];
    bit_val  = (run_length_next > one_threshold);

    if (capturing_next) begin
      if (pin_level == last_level_next) begin
        run_length_next = run_inc;
        if (run_inc >= limit) begin
          done           = 1'b1;
          capturing_next = 1'b0;
        end
      end else begin
        last_level_next = pin_level;
        if (trans_idx_next >= SKIP_T && trans_idx_next[0] == SKIP_T[0]
            && bit_count_next < NBITS) begin
          frame_bytes_next[byte_idx] = {frame_bytes_next[byte_idx][6:0], bit_val};
          bit_count_next = bit_count_next + 6'd1;
        end
        run_length_next = '0;
        trans_idx_next  = trans_idx_next + 7'd1;
        if (trans_idx_next >= MAX_T) begin
          done           = 1'b1;
          capturing_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capturing  <= 1'b0;
      last_level <= 1'b1;
      run_length <= '0;
      trans_idx  <= '0;
      bit_count  <= '0;
    end else if (take) begin
      capturing  <= capturing_next;
      last_level <= last_level_next;
      run_length <= run_length_next;
      trans_idx  <= trans_idx_next;
      bit_count  <= bit_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      frame_bytes <= frame_bytes_next;
    end
  end

  assign push           = take && done;
  assign push_rec.bytes = frame_bytes_next;
  assign push_rec.bits  = bit_count_next;

endmodule

// File: rtl/swsd_back.sv
// back: checksum, status and temperature scaling, then the output register
module swsd_back
  import swsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rec_avail,
  input  frame_rec_t  rec,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_data
);

  logic          a_valid;
  frame_status_t a_status;
  logic          a_sign;
  logic [30:0]   a_prod;
  logic [5:0]    a_bits;

  frame_status_t o_status;
  logic [12:0]   o_temp;
  logic [5:0]    o_bits;

  logic          o_adv;
  logic          a_adv;
  logic [7:0]    sum8;
  frame_status_t status_now;
  logic [14:0]   mag;
  logic [11:0]   quot;
  logic [12:0]   temp_now;

  assign o_adv = !out_valid || out_ready;
  assign a_adv = !a_valid || o_adv;
  assign pop   = rec_avail && a_adv;

  assign sum8 = rec.bytes[0] + rec.bytes[1] + rec.bytes[2] + rec.bytes[3];
  assign mag  = {rec.bytes[2][6:0], rec.bytes[3]};

  always_comb begin
    if (rec.bits < 6'(FRAME_BITS)) begin
      status_now = STATUS_SHORT;
    end else if (rec.bytes[4] != sum8) begin
      status_now = STATUS_CSUM;
    end else begin
      status_now = STATUS_GOOD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_adv) begin
      a_valid <= rec_avail;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_status <= status_now;
      a_sign   <= rec.bytes[2][7];
      a_prod   <= mag * RECIP_TEN;
      a_bits   <= rec.bits;
    end
  end

  assign quot = a_prod[30:RECIP_SHIFT];

  always_comb begin
    if (a_status != STATUS_GOOD) begin
      temp_now = '0;
    end else if (a_sign) begin
      temp_now = 13'd0 - {1'b0, quot};
    end else begin
      temp_now = {1'b0, quot};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_adv) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_adv && a_valid) begin
      o_status <= a_status;
      o_temp   <= temp_now;
      o_bits   <= a_bits;
    end
  end

  assign out_data = {3'b000, o_bits, o_temp, o_status};

endmodule

// File: rtl/single_wire_sensor_frame_decoder_unit.sv
// Single wire sensor frame decoder, top level.
// Input stream: one word per microsecond tick of the sensor line. tdata[0]
// is the sampled pin level, tuser[0] marks the tick that starts a frame
// (bytes and counters clear, and the same tick's sample counts). The pin
// is ignored between frames.
// Output stream: one word per finished frame, carrying status (good, short,
// checksum bad), whole degrees and the number of data bits collected.
// Config channel: index 0 is the one/zero threshold, index 1 the timeout
// run length; always ready, write only while the block is idle.
// Throughput: one tick per cycle. The front counts runs as each tick is
// accepted and pushes a finished frame into a four-entry queue; input ready
// drops only when that queue is full.
// After the word that ends the frame is accepted, its result is popped
// from the queue into the scaling stage, then into the output register.
// A stalled output holds its word while the front keeps sampling, up to
// five further frames (one in the scaling stage, four in the queue).
// Reset: no frame in progress, queue and output empty, threshold 50,
// timeout 255.
module single_wire_sensor_frame_decoder_unit
  import swsd_pkg::*;
#(
  parameter int unsigned MAX_TRANSITIONS  = 85,
  parameter int unsigned SKIP_TRANSITIONS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] pin_level, [7:1] zero
  input  logic [0:0]  s_axis_tuser,   // [0] start_capture
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [1:0] frame_status, [14:2] temperature_c,
                                      // [20:15] bits_received, [23:21] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] one_threshold;
  logic [7:0] timeout_limit;
  logic       take;
  logic       push;
  frame_rec_t push_rec;
  frame_rec_t head_rec;
  logic       q_full;
  logic       q_not_empty;
  logic       pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      one_threshold <= THRESH_RESET;
      timeout_limit <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ONE_THRESHOLD: one_threshold <= cfg_data;
        REG_TIMEOUT_LIMIT: timeout_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !q_full;
  assign take          = s_axis_tvalid && s_axis_tready;

  swsd_front #(
    .MAX_TRANSITIONS  (MAX_TRANSITIONS),
    .SKIP_TRANSITIONS (SKIP_TRANSITIONS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .start_capture (s_axis_tuser[0]),
    .pin_level     (s_axis_tdata[0]),
    .one_threshold (one_threshold),
    .timeout_limit (timeout_limit),
    .push          (push),
    .push_rec      (push_rec)
  );

  swsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (pop),
    .head_rec  (head_rec),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  swsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_avail (q_not_empty),
    .rec       (head_rec),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// File: rtl/swsd_checker.sv
// port-level checker for the frame decoder and its bind
`include "single_wire_sensor_frame_decoder_unit_assert.svh"

module swsd_checker
  import swsd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  `SWSD_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `SWSD_ASSERT_IMP(a_status_code, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3)
  `SWSD_ASSERT_IMP(a_bad_temp_zero, m_axis_tvalid && m_axis_tdata[1:0] != STATUS_GOOD, m_axis_tdata[14:2] == 13'd0)
  `SWSD_ASSERT_IMP(a_good_full, m_axis_tvalid && m_axis_tdata[1:0] == STATUS_GOOD, m_axis_tdata[20:15] == 6'(FRAME_BITS))
  `SWSD_ASSERT_IMP(a_bits_range, m_axis_tvalid, m_axis_tdata[20:15] <= 6'(FRAME_BITS))

endmodule

bind single_wire_sensor_frame_decoder_unit swsd_checker u_swsd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
